### hdl/nnbt_pkg.sv
// Shared constants and codes of the nearest-neighbour blob tracker.
// No dependencies; used by nearest_neighbour_blob_tracker_unit and the testbench.
`default_nettype none

package nnbt_pkg;

	// Defaults of the top-level parameters
	localparam int unsigned MAX_BLOBS_DEF  = 16;
	localparam int unsigned COORD_BITS_DEF = 12;

	// Fixed field widths
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned EV_W    = 3;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned MD_W    = 13;
	localparam int unsigned TOL_W   = 8;
	localparam int unsigned LOST_W  = 8;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned CFG_IX_W = 2;

	// Reset values of the configuration registers
	localparam logic [MD_W-1:0]  MAX_DIST_RST = 13'd50;
	localparam logic [TOL_W-1:0] LOST_TOL_RST = 8'd10;

	// Lost count saturation value
	localparam logic [LOST_W-1:0] LOST_SAT = 8'hFF;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_MAX_DIST = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_LOST_TOL = 2'd1;

	// Input item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_FRAME_START = 2'd0,
		KIND_DETECT      = 2'd1,
		KIND_FRAME_END   = 2'd2
	} kind_t;

	// Result event codes
	typedef enum logic [EV_W-1:0] {
		EV_MATCH      = 3'd0,
		EV_NEW        = 3'd1,
		EV_REMOVED    = 3'd2,
		EV_FRAME_DONE = 3'd3,
		EV_FULL       = 3'd4
	} event_t;

endpackage

`default_nettype wire

### hdl/nearest_neighbour_blob_tracker_unit.sv
// Top level of the nearest-neighbour blob tracker: sequencer, slot table, output register.
// Depends on nnbt_pkg and nnbt_sq_unit.
`default_nettype none

// Tracks touch blobs across frames in a table of MAX_BLOBS slots. Three kinds of input
// beat: frame start clears every active mark and gives no result; a detection gives
// exactly one result (matched, new blob, or table full with the beat dropped); frame
// end gives one "removed" result per expired blob in slot order and then "frame done",
// the only one of that group with last set. A detection matches the valid slot at the
// smallest squared distance (ties to the lowest slot) when that distance is strictly
// below max_distance squared and the slot is not yet active this frame. The block
// takes one beat at a time. A detection occupies the block while it squares the
// limit and scans every slot, and then while it waits for the output register: one
// squaring unit is shared by the limit and by both axes of every slot, so each slot
// is squared on that unit once per axis. Frame end walks the table slot by slot,
// reading the slot memory then acting on it, and each result it gives waits for the
// output register to be free.
// A result waits in an output register, so the next beat may be accepted while it is
// still pending. Configuration is written with cfg_wr_en, taking effect at the next
// clock edge; unknown indexes are ignored.

module nearest_neighbour_blob_tracker_unit #(
	parameter int unsigned MAX_BLOBS  = nnbt_pkg::MAX_BLOBS_DEF,
	parameter int unsigned COORD_BITS = nnbt_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_wr_en,
	input  wire logic [nnbt_pkg::CFG_IX_W-1:0] cfg_index,
	input  wire logic [nnbt_pkg::CFG_W-1:0]    cfg_data,
	// input items
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [nnbt_pkg::KIND_W-1:0]   kind,
	input  wire logic [COORD_BITS-1:0]         x_pos,
	input  wire logic [COORD_BITS-1:0]         y_pos,
	// results
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [nnbt_pkg::EV_W-1:0]          event_res,
	output logic [nnbt_pkg::ID_W-1:0]          blob_id,
	output logic [COORD_BITS-1:0]              x_out,
	output logic [COORD_BITS-1:0]              y_out,
	output logic                               last
);

	// operand width of the shared unit: wide enough for a coordinate and for max_distance
	localparam int unsigned OW = (COORD_BITS > nnbt_pkg::MD_W) ? COORD_BITS : nnbt_pkg::MD_W;
	localparam int unsigned PW = 2 * OW;
	localparam int unsigned DW = PW + 1;
	localparam int unsigned SW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
	localparam int unsigned IW = $clog2(MAX_BLOBS + 1);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_LIM     = 7'b0000010,
		S_SCAN    = 7'b0000100,
		S_DECIDE  = 7'b0001000,
		S_FE_RD   = 7'b0010000,
		S_FE_EV   = 7'b0100000,
		S_FE_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [nnbt_pkg::MD_W-1:0]  max_dist_q;
	logic [nnbt_pkg::TOL_W-1:0] lost_tol_q;

	// per-slot flags in flip-flops, cleared by reset
	logic [MAX_BLOBS-1:0] valid_q;
	logic [MAX_BLOBS-1:0] active_q;
	logic [nnbt_pkg::ID_W-1:0] last_id_q;

	// slot memory: one write port, one registered read port
	logic [nnbt_pkg::ID_W-1:0]   mem_id   [MAX_BLOBS];
	logic [COORD_BITS-1:0]       mem_x    [MAX_BLOBS];
	logic [COORD_BITS-1:0]       mem_y    [MAX_BLOBS];
	logic [nnbt_pkg::LOST_W-1:0] mem_lost [MAX_BLOBS];

	logic [SW-1:0]               rd_addr;
	logic [nnbt_pkg::ID_W-1:0]   rd_id_q;
	logic [COORD_BITS-1:0]       rd_x_q;
	logic [COORD_BITS-1:0]       rd_y_q;
	logic [nnbt_pkg::LOST_W-1:0] rd_lost_q;

	logic                        we_id, we_xy, we_lost;
	logic [SW-1:0]               wr_addr;
	logic [nnbt_pkg::ID_W-1:0]   wr_id;
	logic [nnbt_pkg::LOST_W-1:0] wr_lost;

	// sequencer
	logic [IW-1:0] idx_q;
	logic          ph_q;

	// latched detection
	logic [COORD_BITS-1:0] x_q, y_q;

	// search state
	logic [PW-1:0]             lim_q;
	logic [PW-1:0]             acc_q;
	logic [nnbt_pkg::ID_W-1:0] cand_id_q;
	logic                      best_found_q;
	logic [DW-1:0]             best_d_q;
	logic [SW-1:0]             best_idx_q;
	logic [nnbt_pkg::ID_W-1:0] best_id_q;
	logic                      free_found_q;
	logic [SW-1:0]             free_idx_q;

	// shared unit
	logic [OW-1:0] sq_a, sq_b;
	logic [PW-1:0] prod_q;

	// output register
	logic                        out_valid_q;
	logic [nnbt_pkg::EV_W-1:0]   out_ev_q;
	logic [nnbt_pkg::ID_W-1:0]   out_id_q;
	logic [COORD_BITS-1:0]       out_x_q, out_y_q;
	logic                        out_last_q;

	logic          out_free;
	logic          out_load;
	logic          in_acc;
	logic [SW-1:0] fold_idx;
	logic [DW-1:0] d_sum;
	logic          fold_better;
	logic          scan_end;
	logic          match;
	logic [SW-1:0] fe_idx;
	logic          fe_live, fe_remove, fe_age, fe_end;

	assign item_ready   = (state_q == S_IDLE);
	assign in_acc       = item_valid && item_ready;
	assign out_free     = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign event_res    = out_ev_q;
	assign blob_id      = out_id_q;
	assign x_out        = out_x_q;
	assign y_out        = out_y_q;
	assign last         = out_last_q;

	// scan: slot idx-1 is folded in phase 1, once both of its squares are in
	assign fold_idx    = SW'(idx_q - 1'b1);
	assign d_sum       = DW'(acc_q) + DW'(prod_q);
	assign fold_better = !best_found_q || (d_sum < best_d_q);
	assign scan_end    = (idx_q == IW'(MAX_BLOBS));
	assign match       = best_found_q && (best_d_q < DW'(lim_q)) && !active_q[best_idx_q];

	// frame end walk
	assign fe_idx    = idx_q[SW-1:0];
	assign fe_live   = valid_q[fe_idx] && !active_q[fe_idx];
	assign fe_remove = fe_live && (rd_lost_q > lost_tol_q);
	assign fe_age    = fe_live && !fe_remove && (rd_lost_q != nnbt_pkg::LOST_SAT);
	assign fe_end    = (idx_q == IW'(MAX_BLOBS - 1));

	// a result enters the output register this cycle
	assign out_load = out_free && ((state_q == S_DECIDE) || (state_q == S_FE_DONE) ||
		(state_q == S_FE_EV && fe_remove));

	// read address follows the sequencer index; park at slot 0 past the end
	assign rd_addr = (idx_q < IW'(MAX_BLOBS)) ? idx_q[SW-1:0] : '0;

	// operand select of the shared unit
	always_comb begin
		sq_a = '0;
		sq_b = '0;
		case (state_q)
			S_LIM: begin
				sq_a = OW'(max_dist_q);
			end
			S_SCAN: begin
				if (ph_q) begin
					// dx of slot idx
					sq_a = OW'(x_q);
					sq_b = OW'(rd_x_q);
				end else begin
					// dy of slot idx-1
					sq_a = OW'(y_q);
					sq_b = OW'(rd_y_q);
				end
			end
			default: begin
			end
		endcase
	end

	nnbt_sq_unit #(
		.OP_W (OW)
	) u_sq (
		.clk    (clk),
		.a      (sq_a),
		.b      (sq_b),
		.prod_q (prod_q)
	);

	// slot memory write decode
	always_comb begin
		we_id   = 1'b0;
		we_xy   = 1'b0;
		we_lost = 1'b0;
		wr_addr = best_idx_q;
		wr_id   = last_id_q + 1'b1;
		wr_lost = '0;
		case (state_q)
			S_DECIDE: begin
				if (out_free) begin
					if (match) begin
						we_xy   = 1'b1;
						we_lost = 1'b1;
					end else if (free_found_q) begin
						wr_addr = free_idx_q;
						we_id   = 1'b1;
						we_xy   = 1'b1;
						we_lost = 1'b1;
					end
				end
			end
			S_FE_EV: begin
				wr_addr = fe_idx;
				wr_lost = rd_lost_q + 1'b1;
				we_lost = fe_age;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_id) begin
			mem_id[wr_addr] <= wr_id;
		end
		if (we_xy) begin
			mem_x[wr_addr] <= x_q;
			mem_y[wr_addr] <= y_q;
		end
		if (we_lost) begin
			mem_lost[wr_addr] <= wr_lost;
		end
		rd_id_q   <= mem_id[rd_addr];
		rd_x_q    <= mem_x[rd_addr];
		rd_y_q    <= mem_y[rd_addr];
		rd_lost_q <= mem_lost[rd_addr];
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= x_pos;
			y_q <= y_pos;
		end
		if (state_q == S_SCAN) begin
			if (!ph_q) begin
				// hold dx^2 of the previous slot while its dy^2 is formed
				acc_q     <= prod_q;
				cand_id_q <= rd_id_q;
				if (idx_q == '0) begin
					lim_q <= prod_q;
				end
			end else if (idx_q != '0) begin
				if (valid_q[fold_idx] && fold_better) begin
					best_d_q   <= d_sum;
					best_idx_q <= fold_idx;
					best_id_q  <= cand_id_q;
				end
				if (!valid_q[fold_idx] && !free_found_q) begin
					free_idx_q <= fold_idx;
				end
			end
		end
		// result payload
		if (state_q == S_DECIDE && out_free) begin
			out_x_q    <= x_q;
			out_y_q    <= y_q;
			out_last_q <= 1'b1;
			if (match) begin
				out_ev_q <= nnbt_pkg::EV_MATCH;
				out_id_q <= best_id_q;
			end else if (free_found_q) begin
				out_ev_q <= nnbt_pkg::EV_NEW;
				out_id_q <= last_id_q + 1'b1;
			end else begin
				out_ev_q <= nnbt_pkg::EV_FULL;
				out_id_q <= '0;
			end
		end
		if (state_q == S_FE_EV && fe_remove && out_free) begin
			out_ev_q   <= nnbt_pkg::EV_REMOVED;
			out_id_q   <= rd_id_q;
			out_x_q    <= rd_x_q;
			out_y_q    <= rd_y_q;
			out_last_q <= 1'b0;
		end
		if (state_q == S_FE_DONE && out_free) begin
			out_ev_q   <= nnbt_pkg::EV_FRAME_DONE;
			out_id_q   <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_last_q <= 1'b1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_dist_q   <= nnbt_pkg::MAX_DIST_RST;
			lost_tol_q   <= nnbt_pkg::LOST_TOL_RST;
			valid_q      <= '0;
			active_q     <= '0;
			last_id_q    <= '0;
			idx_q        <= '0;
			ph_q         <= 1'b0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					nnbt_pkg::CFG_MAX_DIST: max_dist_q <= cfg_data[nnbt_pkg::MD_W-1:0];
					nnbt_pkg::CFG_LOST_TOL: lost_tol_q <= cfg_data[nnbt_pkg::TOL_W-1:0];
					default: begin
					end
				endcase
			end

			// load a new result, else drop the one just taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					ph_q  <= 1'b0;
					if (in_acc) begin
						case (kind)
							nnbt_pkg::KIND_FRAME_START: active_q <= '0;
							nnbt_pkg::KIND_DETECT:      state_q  <= S_LIM;
							nnbt_pkg::KIND_FRAME_END:   state_q  <= S_FE_RD;
							default: begin
							end
						endcase
					end
				end
				S_LIM: begin
					// square max_distance; the scan latches it on its first cycle
					best_found_q <= 1'b0;
					free_found_q <= 1'b0;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						if (idx_q != '0) begin
							if (valid_q[fold_idx] && fold_better) begin
								best_found_q <= 1'b1;
							end
							if (!valid_q[fold_idx]) begin
								free_found_q <= 1'b1;
							end
						end
						ph_q <= 1'b0;
						if (scan_end) begin
							state_q <= S_DECIDE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						if (match) begin
							active_q[best_idx_q] <= 1'b1;
						end else if (free_found_q) begin
							last_id_q            <= last_id_q + 1'b1;
							valid_q[free_idx_q]  <= 1'b1;
							active_q[free_idx_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				S_FE_RD: begin
					state_q <= S_FE_EV;
				end
				S_FE_EV: begin
					// a removal waits for the output register; ageing never does
					if (!fe_remove || out_free) begin
						if (fe_remove) begin
							valid_q[fe_idx] <= 1'b0;
						end
						if (fe_end) begin
							state_q <= S_FE_DONE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_FE_RD;
						end
					end
				end
				S_FE_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a new blob advances the ID counter by exactly one, wrapping
	a_new_id: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && out_free && !match && free_found_q)
		|=> (last_id_q == $past(last_id_q) + 16'd1))
		else $error("blob ID counter did not advance on a new blob");

	// a matched slot is marked active for the rest of the frame
	a_match_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && out_free && match)
		|=> (active_q[$past(best_idx_q)] && out_valid_q))
		else $error("matched slot not marked active");

	// the scan never runs past the drain step
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= IW'(MAX_BLOBS)))
		else $error("scan index out of range");

	// a removal at frame end loads a result without last and frees its slot
	a_fe_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FE_EV && fe_remove && out_free)
		|=> (out_valid_q && !out_last_q && !valid_q[$past(fe_idx)]))
		else $error("removal result without clearing the slot");

endmodule

`default_nettype wire

### hdl/nnbt_sq_unit.sv
// Shared squaring unit of the blob tracker: registered (a - b)^2, unsigned.
// No package dependencies; instantiated by nearest_neighbour_blob_tracker_unit.
`default_nettype none

module nnbt_sq_unit #(
	parameter int unsigned OP_W = 13
) (
	input  wire logic                clk,
	input  wire logic [OP_W-1:0]     a,
	input  wire logic [OP_W-1:0]     b,
	output logic      [2*OP_W-1:0]   prod_q
);

	logic [OP_W-1:0] diff;

	// absolute difference, then square
	assign diff = (a >= b) ? (a - b) : (b - a);

	always_ff @(posedge clk) begin
		prod_q <= {{OP_W{1'b0}}, diff} * {{OP_W{1'b0}}, diff};
	end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for nearest_neighbour_blob_tracker_unit: directed and random beats,
// with an in-bench slot table that predicts every result and a scoreboard that checks each one.
// Depends on nnbt_pkg and the RTL of the tracker only.
`timescale 1ns / 100ps

module tb_top;
	import nnbt_pkg::*;

	localparam int SLOTS         = MAX_BLOBS_DEF;
	localparam int COORD_W       = COORD_BITS_DEF;
	localparam int COORD_MAX     = (1 << COORD_W) - 1;
	// tail of settle_block, long enough to outlast the slot scan of a detection
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

	// codes the package leaves unnamed: the unused kind and the unused register indexes
	localparam logic [KIND_W-1:0]   KIND_UNUSED = 2'd3;
	localparam logic [CFG_IX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct {
		event_t              ev;
		logic [ID_W-1:0]     id;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic                is_last;
	} track_result_t;

	// ---------------------------------------------------------------- DUT signals
	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 item_valid;
	logic                 item_ready;
	logic [KIND_W-1:0]    kind;
	logic [COORD_W-1:0]   x_pos;
	logic [COORD_W-1:0]   y_pos;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [EV_W-1:0]      event_res;
	logic [ID_W-1:0]      blob_id;
	logic [COORD_W-1:0]   x_out;
	logic [COORD_W-1:0]   y_out;
	logic                 last;

	nearest_neighbour_blob_tracker_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.event_res    (event_res),
		.blob_id      (blob_id),
		.x_out        (x_out),
		.y_out        (y_out),
		.last         (last)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- tracker shadow state
	// Our own copy of the slot table and registers; updated as each beat is accepted.
	logic                 trk_valid  [SLOTS] = '{default: 1'b0};
	logic                 trk_active [SLOTS] = '{default: 1'b0};
	logic [ID_W-1:0]      trk_id     [SLOTS] = '{default: '0};
	logic [COORD_W-1:0]   trk_x      [SLOTS] = '{default: '0};
	logic [COORD_W-1:0]   trk_y      [SLOTS] = '{default: '0};
	logic [LOST_W-1:0]    trk_lost   [SLOTS] = '{default: '0};
	logic [ID_W-1:0]      trk_last_id = '0;
	logic [MD_W-1:0]      cfg_max_dist = MAX_DIST_RST;
	logic [TOL_W-1:0]     cfg_lost_tol = LOST_TOL_RST;

	track_result_t expected_results[$];
	track_result_t head_res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats_sent = 0;
	int results_checked = 0;
	int fail_count = 0;
	int events_seen [5] = '{default: 0};

	function automatic void push_result(input event_t ev, input logic [ID_W-1:0] id,
			input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py, input logic fin);
		track_result_t r;
		r.ev      = ev;
		r.id      = id;
		r.x       = px;
		r.y       = py;
		r.is_last = fin;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic logic [31:0] axis_gap_sq(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic [31:0] gap;
		gap = (a > b) ? a - b : b - a;
		return gap * gap;
	endfunction

	// Nearest stored blob wins, ties to the lowest slot; match only if strictly inside the
	// radius and not already claimed this frame, otherwise take the lowest free slot.
	function automatic void track_detection(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py);
		int          best;
		logic [31:0] best_d;
		logic [31:0] d;
		logic [31:0] radius_sq;
		best      = -1;
		best_d    = '0;
		radius_sq = 32'(cfg_max_dist) * 32'(cfg_max_dist);
		for (int i = 0; i < SLOTS; i++) begin
			if (trk_valid[i]) begin
				d = axis_gap_sq(px, trk_x[i]) + axis_gap_sq(py, trk_y[i]);
				if (best < 0 || d < best_d) begin
					best   = i;
					best_d = d;
				end
			end
		end
		if (best >= 0 && best_d < radius_sq && !trk_active[best]) begin
			trk_x[best]      = px;
			trk_y[best]      = py;
			trk_active[best] = 1'b1;
			trk_lost[best]   = '0;
			push_result(EV_MATCH, trk_id[best], px, py, 1'b1);
			return;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (!trk_valid[i]) begin
				trk_last_id   = trk_last_id + 1'b1;
				trk_valid[i]  = 1'b1;
				trk_id[i]     = trk_last_id;
				trk_x[i]      = px;
				trk_y[i]      = py;
				trk_active[i] = 1'b0;
				trk_lost[i]   = '0;
				push_result(EV_NEW, trk_last_id, px, py, 1'b1);
				return;
			end
		end
		// table full: drop the detection, echo its position
		push_result(EV_FULL, '0, px, py, 1'b1);
	endfunction

	// Expire unseen blobs past the tolerance, age the rest (saturating), then close the frame.
	function automatic void track_frame_end();
		for (int i = 0; i < SLOTS; i++) begin
			if (trk_valid[i] && !trk_active[i]) begin
				if (trk_lost[i] > cfg_lost_tol) begin
					push_result(EV_REMOVED, trk_id[i], trk_x[i], trk_y[i], 1'b0);
					trk_valid[i] = 1'b0;
				end else if (trk_lost[i] != LOST_SAT) begin
					trk_lost[i] = trk_lost[i] + 1'b1;
				end
			end
		end
		push_result(EV_FRAME_DONE, '0, '0, '0, 1'b1);
	endfunction

	function automatic void track_beat(input logic [KIND_W-1:0] k,
			input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
		case (k)
			KIND_FRAME_START: begin
				for (int i = 0; i < SLOTS; i++)
					trk_active[i] = 1'b0;
			end
			KIND_DETECT:    track_detection(px, py);
			KIND_FRAME_END: track_frame_end();
			default: ;  // unused kind: no effect
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return '1;
		return v[COORD_W-1:0];
	endfunction

	// ---------------------------------------------------------------- result side
	// Drop ready at random on the falling edge; the percentage follows the current phase.
	always @(negedge clk) begin
		result_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Check each result beat against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: event_res %0d blob_id %0d", event_res, blob_id);
				fail_count++;
			end else begin
				head_res = expected_results.pop_front();
				results_checked++;
				events_seen[head_res.ev]++;
				if (event_res !== head_res.ev) begin
					$error("event_res: expected %0d, got %0d", head_res.ev, event_res);
					fail_count++;
				end
				if (blob_id !== head_res.id) begin
					$error("blob_id: expected %0d, got %0d", head_res.id, blob_id);
					fail_count++;
				end
				if (x_out !== head_res.x) begin
					$error("x_out: expected %0d, got %0d", head_res.x, x_out);
					fail_count++;
				end
				if (y_out !== head_res.y) begin
					$error("y_out: expected %0d, got %0d", head_res.y, y_out);
					fail_count++;
				end
				if (last !== head_res.is_last) begin
					$error("last: expected %0d, got %0d", head_res.is_last, last);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- input side
	// Offer one beat, idling first at the phase's rate; hold valid and payload until taken.
	task automatic send_beat(input logic [KIND_W-1:0] k, input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		kind       = k;
		x_pos      = px;
		y_pos      = py;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		track_beat(k, px, py);
		beats_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = ix;
		cfg_data  = data;
		@(posedge clk);
		// unused indexes are ignored; values are cut to the register width
		if (ix == CFG_MAX_DIST)
			cfg_max_dist = data[MD_W-1:0];
		else if (ix == CFG_LOST_TOL)
			cfg_lost_tol = data[TOL_W-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Drain: stop offering, wait for every expected result, then let the block go quiet.
	// A frame start gives no result, so the fixed tail covers it.
	task automatic settle_block();
		@(negedge clk);
		item_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(input logic [CFG_W-1:0] md_data,
			input logic [CFG_W-1:0] tol_data);
		settle_block();
		write_reg(CFG_MAX_DIST, md_data);
		write_reg(CFG_LOST_TOL, tol_data);
		// a write to an unused index must leave both registers alone
		write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_W'($urandom));
	endtask

	// Mostly jitter around a live blob so matches happen; sometimes land right on the
	// radius, sometimes anywhere in the frame.
	task automatic pick_position(output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
		int live[$];
		int roll;
		int slot;
		int span;
		int dx;
		int dy;
		for (int i = 0; i < SLOTS; i++)
			if (trk_valid[i])
				live.insert(live.size(), i);
		roll = $urandom_range(99);
		if (live.size() != 0 && roll < 60) begin
			slot = live[$urandom_range(live.size() - 1)];
			span = int'(cfg_max_dist) / 2;
			if (span > 300)
				span = 300;
			if (span < 1)
				span = 1;
			dx = int'($urandom_range(2 * span)) - span;
			dy = int'($urandom_range(2 * span)) - span;
			px = clamp_coord(int'(trk_x[slot]) + dx);
			py = clamp_coord(int'(trk_y[slot]) + dy);
		end else if (live.size() != 0 && roll < 72) begin
			// on or just inside the radius along one axis
			slot = live[$urandom_range(live.size() - 1)];
			dx   = int'(cfg_max_dist) - int'($urandom_range(1));
			px   = clamp_coord(int'(trk_x[slot]) + ($urandom_range(1) ? dx : -dx));
			py   = trk_y[slot];
		end else begin
			px = COORD_W'($urandom);
			py = COORD_W'($urandom);
		end
	endtask

	// ---------------------------------------------------------------- tests
	// Match, new blob, ties, an active nearest blob forcing a new one, ageing at frame end.
	task automatic test_directed_tracking();
		send_beat(KIND_FRAME_START, '0, '0);
		send_beat(KIND_UNUSED, COORD_W'(COORD_MAX), '0);
		send_beat(KIND_DETECT, '0, '0);
		send_beat(KIND_DETECT, COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
		send_beat(KIND_DETECT, 12'd3, 12'd4);
		// same spot again: nearest is now active, so a new blob is made
		send_beat(KIND_DETECT, 12'd3, 12'd4);
		// tie between an active and an inactive blob, lowest slot is the active one
		send_beat(KIND_DETECT, 12'd10, 12'd10);
		send_beat(KIND_DETECT, COORD_W'(COORD_MAX), 12'd4050);
		send_beat(KIND_FRAME_END, '1, '1);
		send_beat(KIND_FRAME_START, '1, '0);
	endtask

	// Fill the table with matching off, overflow it, then expire every slot in one frame end.
	task automatic test_table_full_and_expiry();
		set_registers('0, CFG_W'(LOST_TOL_RST));
		for (int j = 0; j < SLOTS - 4; j++)
			send_beat(KIND_DETECT, COORD_W'(300 * j + 11), COORD_W'(COORD_MAX - 250 * j));
		send_beat(KIND_DETECT, 12'd2048, 12'd2048);
		send_beat(KIND_FRAME_END, '0, '0);
		// upper bits beyond the register are dropped: tolerance becomes zero
		set_registers('0, 13'h1F00);
		send_beat(KIND_FRAME_END, '0, '1);
	endtask

	// Frames of random content, with stray kinds, missing frame starts and missing frame ends.
	task automatic test_random_frames(input int n_beats);
		int done_beats;
		int n_det;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		done_beats = 0;
		while (done_beats < n_beats) begin
			if ($urandom_range(9) != 0) begin
				send_beat(KIND_FRAME_START, COORD_W'($urandom), COORD_W'($urandom));
				done_beats++;
			end
			n_det = $urandom_range(6);
			for (int j = 0; j < n_det; j++) begin
				pick_position(px, py);
				send_beat(KIND_DETECT, px, py);
				done_beats++;
				if ($urandom_range(19) == 0)
					send_beat(KIND_UNUSED, COORD_W'($urandom), COORD_W'($urandom));
			end
			if ($urandom_range(9) != 0) begin
				send_beat(KIND_FRAME_END, COORD_W'($urandom), COORD_W'($urandom));
				done_beats++;
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		item_valid = 1'b0;
		kind       = '0;
		x_pos      = '0;
		y_pos      = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles a quarter of the time, receiver mostly stalls
		send_idle_pct = 25;
		recv_idle_pct = 81;
		test_directed_tracking();
		test_table_full_and_expiry();
		set_registers(13'd8191, 13'd254);
		test_random_frames(45);
		set_registers(CFG_W'($urandom_range(20, 400)), CFG_W'($urandom_range(4)));
		test_random_frames(45);

		// swap the pressure round
		send_idle_pct = 81;
		recv_idle_pct = 25;
		set_registers('0, '0);
		test_random_frames(45);
		set_registers(CFG_W'($urandom_range(1, 60)), 13'h0FF);
		test_random_frames(45);

		// flat out
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_registers(CFG_W'($urandom_range(8191)),
			{5'($urandom), 8'($urandom_range(6))});
		test_random_frames(45);
		set_registers(CFG_W'(MAX_DIST_RST), CFG_W'(LOST_TOL_RST));
		test_random_frames(45);

		settle_block();
		$display("tb_top: %0d beats sent, %0d results checked", beats_sent, results_checked);
		$display("tb_top: matched %0d, new %0d, removed %0d, frames closed %0d, dropped %0d",
			events_seen[EV_MATCH], events_seen[EV_NEW], events_seen[EV_REMOVED],
			events_seen[EV_FRAME_DONE], events_seen[EV_FULL]);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Watchdog: ends the run as a failure if the sequence has not finished.
	initial begin
		#8_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
